FILE: hdl/clqm_pkg.sv
// Shared types and constants for the control loop quality metrics block.
package clqm_pkg;

  localparam int unsigned ERR_W   = 24;
  localparam int unsigned DT_W    = 16;
  localparam int unsigned ACC_W   = 63;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned TERM_W  = 55;
  localparam int unsigned PROD_W  = 80;
  localparam int unsigned MEAN_W  = 24;
  localparam int unsigned DUTY_W  = 17;
  localparam int unsigned OSC_W   = 40;
  localparam int unsigned STEP_W  = 6;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 472;

  localparam logic [MEAN_W-1:0] MEAN_CAP = 24'd8388608;
  localparam logic [DUTY_W-1:0] DUTY_CAP = 17'd65536;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CLEAR,
    ST_MUL_LOAD,
    ST_MUL_RUN,
    ST_MUL_STORE,
    ST_COMMIT,
    ST_RATIOS,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_STORE,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MUL_IAE,
    MUL_SQ,
    MUL_ISE,
    MUL_TW1,
    MUL_TW2
  } mul_op_t;

  typedef enum logic [1:0] {
    DIV_MEAN,
    DIV_DUTY,
    DIV_OSC
  } div_op_t;

  typedef struct packed {
    logic    load_in;
    logic    clear;
    logic    reject;
    logic    mul_load;
    logic    mul_step;
    logic    mul_store;
    logic    commit;
    logic    zero_ratios;
    logic    div_load;
    logic    div_step;
    logic    div_store;
    mul_op_t mul_op;
    div_op_t div_op;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic dt_zero;
    logic elapsed_zero;
  } stat_t;

endpackage

FILE: hdl/clqm_ctrl.sv
// Sequencer that steps the shared multiplier and divider for each sample.
module clqm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                out_fire,
  input  clqm_pkg::stat_t     stat,
  output clqm_pkg::cmd_t      cmd,
  output logic                in_ready,
  output logic                out_valid
);

  clqm_pkg::state_t                  state_r, state_nxt;
  clqm_pkg::mul_op_t                 mul_op_r, mul_op_nxt;
  clqm_pkg::div_op_t                 div_op_r, div_op_nxt;
  logic [clqm_pkg::STEP_W-1:0]       cnt_r, cnt_nxt;
  logic [clqm_pkg::STEP_W-1:0]       mul_steps, div_steps;

  always_comb begin
    unique case (mul_op_r)
      clqm_pkg::MUL_SQ, clqm_pkg::MUL_TW1: mul_steps = 6'd23;
      default:                             mul_steps = 6'd15;
    endcase
    unique case (div_op_r)
      clqm_pkg::DIV_MEAN: div_steps = 6'd23;
      clqm_pkg::DIV_DUTY: div_steps = 6'd16;
      default:            div_steps = 6'd39;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= clqm_pkg::ST_IDLE;
      mul_op_r <= clqm_pkg::MUL_IAE;
      div_op_r <= clqm_pkg::DIV_MEAN;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      mul_op_r <= mul_op_nxt;
      div_op_r <= div_op_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    mul_op_nxt = mul_op_r;
    div_op_nxt = div_op_r;
    cnt_nxt    = cnt_r;
    unique case (state_r)
      clqm_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = clqm_pkg::ST_DECIDE;
      end
      clqm_pkg::ST_DECIDE: begin
        mul_op_nxt = clqm_pkg::MUL_IAE;
        if (stat.action) state_nxt = clqm_pkg::ST_CLEAR;
        else if (stat.dt_zero) state_nxt = clqm_pkg::ST_RATIOS;
        else state_nxt = clqm_pkg::ST_MUL_LOAD;
      end
      clqm_pkg::ST_CLEAR: state_nxt = clqm_pkg::ST_RATIOS;
      clqm_pkg::ST_MUL_LOAD: begin
        cnt_nxt   = mul_steps;
        state_nxt = clqm_pkg::ST_MUL_RUN;
      end
      clqm_pkg::ST_MUL_RUN: begin
        if (cnt_r == '0) state_nxt = clqm_pkg::ST_MUL_STORE;
        else cnt_nxt = cnt_r - 6'd1;
      end
      clqm_pkg::ST_MUL_STORE: begin
        if (mul_op_r == clqm_pkg::MUL_TW2) begin
          state_nxt = clqm_pkg::ST_COMMIT;
        end else begin
          mul_op_nxt = clqm_pkg::mul_op_t'(mul_op_r + 3'd1);
          state_nxt  = clqm_pkg::ST_MUL_LOAD;
        end
      end
      clqm_pkg::ST_COMMIT: state_nxt = clqm_pkg::ST_RATIOS;
      clqm_pkg::ST_RATIOS: begin
        div_op_nxt = clqm_pkg::DIV_MEAN;
        if (stat.elapsed_zero) state_nxt = clqm_pkg::ST_OUT;
        else state_nxt = clqm_pkg::ST_DIV_LOAD;
      end
      clqm_pkg::ST_DIV_LOAD: begin
        cnt_nxt   = div_steps;
        state_nxt = clqm_pkg::ST_DIV_RUN;
      end
      clqm_pkg::ST_DIV_RUN: begin
        if (cnt_r == '0) state_nxt = clqm_pkg::ST_DIV_STORE;
        else cnt_nxt = cnt_r - 6'd1;
      end
      clqm_pkg::ST_DIV_STORE: begin
        if (div_op_r == clqm_pkg::DIV_OSC) begin
          state_nxt = clqm_pkg::ST_OUT;
        end else begin
          div_op_nxt = clqm_pkg::div_op_t'(div_op_r + 2'd1);
          state_nxt  = clqm_pkg::ST_DIV_LOAD;
        end
      end
      clqm_pkg::ST_OUT: begin
        if (out_fire) state_nxt = clqm_pkg::ST_IDLE;
      end
      default: state_nxt = clqm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.mul_op      = mul_op_r;
    cmd.div_op      = div_op_r;
    cmd.load_in     = (state_r == clqm_pkg::ST_IDLE) && in_fire;
    cmd.clear       = (state_r == clqm_pkg::ST_CLEAR);
    cmd.reject      = (state_r == clqm_pkg::ST_DECIDE) && !stat.action && stat.dt_zero;
    cmd.mul_load    = (state_r == clqm_pkg::ST_MUL_LOAD);
    cmd.mul_step    = (state_r == clqm_pkg::ST_MUL_RUN);
    cmd.mul_store   = (state_r == clqm_pkg::ST_MUL_STORE);
    cmd.commit      = (state_r == clqm_pkg::ST_COMMIT);
    cmd.zero_ratios = (state_r == clqm_pkg::ST_RATIOS) && stat.elapsed_zero;
    cmd.div_load    = (state_r == clqm_pkg::ST_DIV_LOAD);
    cmd.div_step    = (state_r == clqm_pkg::ST_DIV_RUN);
    cmd.div_store   = (state_r == clqm_pkg::ST_DIV_STORE);
    in_ready        = (state_r == clqm_pkg::ST_IDLE);
    out_valid       = (state_r == clqm_pkg::ST_OUT);
  end

endmodule

FILE: hdl/clqm_dp.sv
// Datapath with metric state, a shift-add multiplier and a restoring divider.
module clqm_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  clqm_pkg::cmd_t                  cmd,
  input  logic                            in_action,
  input  logic [clqm_pkg::IN_DATA_W-1:0]  in_data,
  output clqm_pkg::stat_t                 stat,
  output logic [clqm_pkg::OUT_DATA_W-1:0] out_data
);

  logic                          action_r, sat_in_r, status_r, primed_r;
  logic [clqm_pkg::ERR_W-1:0]    err_r, drv_r, prev_out_r, prev_err_r, peak_r;
  logic [clqm_pkg::DT_W-1:0]     dt_r;
  logic [clqm_pkg::ACC_W-1:0]    iae_r, ise_r, itae_r;
  logic [clqm_pkg::TIME_W-1:0]   elapsed_r, sat_dur_r, travel_r;
  logic [clqm_pkg::CNT_W-1:0]    sign_r;
  logic [clqm_pkg::TERM_W-1:0]   t_iae_r, t_ise_r, t_itae_r, sq_r, x_r;
  logic [clqm_pkg::PROD_W-1:0]   mcand_r, prod_r;
  logic [clqm_pkg::ERR_W-1:0]    mplier_r;
  logic [clqm_pkg::PROD_W-1:0]   numsh_r;
  logic [clqm_pkg::TIME_W-1:0]   rem_r;
  logic [clqm_pkg::OSC_W-1:0]    quo_r;
  logic                          ovf_r;
  logic [clqm_pkg::MEAN_W-1:0]   mean_r;
  logic [clqm_pkg::DUTY_W-1:0]   duty_r;
  logic [clqm_pkg::OSC_W-1:0]    osc_r;

  logic [clqm_pkg::ERR_W-1:0]    ae;
  logic [clqm_pkg::TERM_W-1:0]   prod_sh;
  logic [clqm_pkg::PROD_W-1:0]   num, num_hi, num_al;
  logic [clqm_pkg::TIME_W:0]     r2;
  logic [clqm_pkg::ERR_W:0]      diff, adiff;
  logic [63:0]                   iae_s, ise_s, itae_s;
  logic [clqm_pkg::TIME_W:0]     el_s, st_s, tr_s;
  logic                          sign_flip;

  assign ae      = err_r[23] ? (~err_r + 24'd1) : err_r;
  assign prod_sh = prod_r[16 +: clqm_pkg::TERM_W];
  assign r2      = {rem_r, numsh_r[clqm_pkg::PROD_W-1]};
  assign diff    = {drv_r[23], drv_r} - {prev_out_r[23], prev_out_r};
  assign adiff   = diff[24] ? (~diff + 25'd1) : diff;
  assign iae_s   = {1'b0, iae_r} + 64'(t_iae_r);
  assign ise_s   = {1'b0, ise_r} + 64'(t_ise_r);
  assign itae_s  = {1'b0, itae_r} + 64'(t_itae_r);
  assign el_s    = {1'b0, elapsed_r} + 49'(dt_r);
  assign st_s    = {1'b0, sat_dur_r} + 49'(dt_r);
  assign tr_s    = {1'b0, travel_r} + 49'(adiff);
  assign sign_flip = (!prev_err_r[23] && prev_err_r != '0 && err_r[23]) ||
                     (prev_err_r[23] && !err_r[23] && err_r != '0);

  always_comb begin
    unique case (cmd.div_op)
      clqm_pkg::DIV_MEAN: begin
        num    = {1'b0, iae_r, 16'd0};
        num_hi = num >> clqm_pkg::MEAN_W;
        num_al = num << (clqm_pkg::PROD_W - clqm_pkg::MEAN_W);
      end
      clqm_pkg::DIV_DUTY: begin
        num    = {16'd0, sat_dur_r, 16'd0};
        num_hi = num >> clqm_pkg::DUTY_W;
        num_al = num << (clqm_pkg::PROD_W - clqm_pkg::DUTY_W);
      end
      default: begin
        num    = {16'd0, sign_r, 32'd0};
        num_hi = num >> clqm_pkg::OSC_W;
        num_al = num << (clqm_pkg::PROD_W - clqm_pkg::OSC_W);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      action_r <= in_action;
      err_r    <= in_data[23:0];
      dt_r     <= in_data[39:24];
      drv_r    <= in_data[63:40];
      sat_in_r <= in_data[64];
    end
    if (cmd.mul_load) begin
      prod_r <= '0;
      unique case (cmd.mul_op)
        clqm_pkg::MUL_IAE: begin mcand_r <= 80'(ae); mplier_r <= 24'(dt_r); end
        clqm_pkg::MUL_SQ:  begin mcand_r <= 80'(ae); mplier_r <= ae; end
        clqm_pkg::MUL_ISE: begin mcand_r <= 80'(sq_r); mplier_r <= 24'(dt_r); end
        clqm_pkg::MUL_TW1: begin mcand_r <= 80'(elapsed_r); mplier_r <= ae; end
        default:           begin mcand_r <= 80'(x_r); mplier_r <= 24'(dt_r); end
      endcase
    end
    if (cmd.mul_step) begin
      if (mplier_r[0]) prod_r <= prod_r + mcand_r;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
    if (cmd.mul_store) begin
      unique case (cmd.mul_op)
        clqm_pkg::MUL_IAE: t_iae_r  <= prod_sh;
        clqm_pkg::MUL_SQ:  sq_r     <= prod_sh;
        clqm_pkg::MUL_ISE: t_ise_r  <= prod_sh;
        clqm_pkg::MUL_TW1: x_r      <= prod_sh;
        default:           t_itae_r <= prod_sh;
      endcase
    end
    if (cmd.div_load) begin
      ovf_r   <= (num_hi >= 80'(elapsed_r));
      rem_r   <= num_hi[clqm_pkg::TIME_W-1:0];
      numsh_r <= num_al;
      quo_r   <= '0;
    end
    if (cmd.div_step) begin
      numsh_r <= numsh_r << 1;
      if (r2 >= {1'b0, elapsed_r}) begin
        rem_r <= 48'(r2 - {1'b0, elapsed_r});
        quo_r <= {quo_r[clqm_pkg::OSC_W-2:0], 1'b1};
      end else begin
        rem_r <= r2[clqm_pkg::TIME_W-1:0];
        quo_r <= {quo_r[clqm_pkg::OSC_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r   <= 1'b0;
      iae_r      <= '0;
      ise_r      <= '0;
      itae_r     <= '0;
      elapsed_r  <= '0;
      peak_r     <= '0;
      sat_dur_r  <= '0;
      travel_r   <= '0;
      sign_r     <= '0;
      primed_r   <= 1'b0;
      prev_out_r <= '0;
      prev_err_r <= '0;
      mean_r     <= '0;
      duty_r     <= '0;
      osc_r      <= '0;
    end else begin
      if (cmd.reject) status_r <= 1'b1;
      if (cmd.clear) begin
        status_r   <= 1'b0;
        iae_r      <= '0;
        ise_r      <= '0;
        itae_r     <= '0;
        elapsed_r  <= '0;
        peak_r     <= '0;
        sat_dur_r  <= '0;
        travel_r   <= '0;
        sign_r     <= '0;
        primed_r   <= 1'b0;
        prev_out_r <= '0;
        prev_err_r <= '0;
      end
      if (cmd.commit) begin
        status_r  <= 1'b0;
        iae_r     <= iae_s[63] ? '1 : iae_s[clqm_pkg::ACC_W-1:0];
        ise_r     <= ise_s[63] ? '1 : ise_s[clqm_pkg::ACC_W-1:0];
        itae_r    <= itae_s[63] ? '1 : itae_s[clqm_pkg::ACC_W-1:0];
        elapsed_r <= el_s[clqm_pkg::TIME_W] ? '1 : el_s[clqm_pkg::TIME_W-1:0];
        if (ae > peak_r) peak_r <= ae;
        if (sat_in_r) begin
          sat_dur_r <= st_s[clqm_pkg::TIME_W] ? '1 : st_s[clqm_pkg::TIME_W-1:0];
        end
        if (primed_r) begin
          travel_r <= tr_s[clqm_pkg::TIME_W] ? '1 : tr_s[clqm_pkg::TIME_W-1:0];
          if (sign_flip && sign_r != '1) sign_r <= sign_r + 32'd1;
        end
        primed_r   <= 1'b1;
        prev_out_r <= drv_r;
        prev_err_r <= err_r;
      end
      if (cmd.zero_ratios) begin
        mean_r <= '0;
        duty_r <= '0;
        osc_r  <= '0;
      end
      if (cmd.div_store) begin
        unique case (cmd.div_op)
          clqm_pkg::DIV_MEAN:
            mean_r <= (ovf_r || quo_r[clqm_pkg::MEAN_W-1:0] > clqm_pkg::MEAN_CAP) ?
                      clqm_pkg::MEAN_CAP : quo_r[clqm_pkg::MEAN_W-1:0];
          clqm_pkg::DIV_DUTY:
            duty_r <= (ovf_r || quo_r[clqm_pkg::DUTY_W-1:0] > clqm_pkg::DUTY_CAP) ?
                      clqm_pkg::DUTY_CAP : quo_r[clqm_pkg::DUTY_W-1:0];
          default:
            osc_r <= ovf_r ? '1 : quo_r;
        endcase
      end
    end
  end

  assign stat.action       = action_r;
  assign stat.dt_zero      = (dt_r == '0);
  assign stat.elapsed_zero = (elapsed_r == '0);

  assign out_data = {1'b0, osc_r, duty_r, mean_r, sign_r, travel_r, sat_dur_r, peak_r,
                     elapsed_r, itae_r, ise_r, iae_r, status_r};

endmodule

FILE: hdl/control_loop_quality_metrics.sv
// Top level of the control loop quality metrics block.
// One sample at a time: a new input beat is not taken until the result beat of the last one
// has been sent, and the next beat can be taken in the cycle after the result beat. A clear
// skips the multiplier and the divider, and a rejected sample skips the multiplier and uses
// the divider only when the elapsed time is nonzero.
// Synchronous active-low reset zeroes all metrics and returns to idle.
module control_loop_quality_metrics (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // loop_error[23:0], time_step[39:24], drive_output[63:40], saturated[64], zero pad.
  input  logic [clqm_pkg::IN_DATA_W-1:0]  in_tdata,
  // action[0].
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status[0], iae[63:1], ise[126:64], itae[189:127], elapsed_time[237:190],
  // peak_abs_err[261:238], sat_duration[309:262], drive_travel[357:310],
  // sign_flips[389:358], mean_abs_error[413:390], saturation_duty[430:414],
  // oscillation_rate[470:431], zero pad.
  output logic [clqm_pkg::OUT_DATA_W-1:0] out_tdata
);

  clqm_pkg::cmd_t  cmd;
  clqm_pkg::stat_t stat;
  logic            in_fire, out_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  clqm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .out_fire  (out_fire),
    .stat      (stat),
    .cmd       (cmd),
    .in_ready  (in_tready),
    .out_valid (out_tvalid)
  );

  clqm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_action (in_tuser),
    .in_data   (in_tdata),
    .stat      (stat),
    .out_data  (out_tdata)
  );

  a_one_side : assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid)) else $error("input and output open together");

  a_busy : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready) else $error("second beat taken while busy");

  a_zero_ratio : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[237:190] == '0) |->
    (out_tdata[470:390] == '0)) else $error("ratio nonzero at zero time");

  a_duty_cap : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[430:414] <= clqm_pkg::DUTY_CAP))
    else $error("duty above one");

endmodule
